// ----- design/des_rf_pkg.sv -----
// DES round function package: E and P selection tables, the eight S-boxes
// and helper functions used by the round function datapath.
// No dependencies.
`timescale 1ns / 1ps

package des_rf_pkg;

    // Field widths of the round function.
    localparam int HalfWidth   = 32;
    localparam int KeyWidth    = 48;
    localparam int NumBoxes    = 8;
    localparam int BoxInWidth  = 6;
    localparam int BoxOutWidth = 4;

    typedef logic [HalfWidth-1:0] half_t;
    typedef logic [KeyWidth-1:0]  key_t;
    typedef logic [5:0]           sel_t;
    typedef logic [BoxOutWidth-1:0] nibble_t;

    // Expansion table E; entries name bit positions with bit 1 as the MSB.
    localparam sel_t E_SEL [0:KeyWidth-1] = '{
        6'd32, 6'd1,  6'd2,  6'd3,  6'd4,  6'd5,  6'd4,  6'd5,
        6'd6,  6'd7,  6'd8,  6'd9,  6'd8,  6'd9,  6'd10, 6'd11,
        6'd12, 6'd13, 6'd12, 6'd13, 6'd14, 6'd15, 6'd16, 6'd17,
        6'd16, 6'd17, 6'd18, 6'd19, 6'd20, 6'd21, 6'd20, 6'd21,
        6'd22, 6'd23, 6'd24, 6'd25, 6'd24, 6'd25, 6'd26, 6'd27,
        6'd28, 6'd29, 6'd28, 6'd29, 6'd30, 6'd31, 6'd32, 6'd1
    };

    // Permutation table P; bit 1 is the MSB.
    localparam sel_t P_SEL [0:HalfWidth-1] = '{
        6'd16, 6'd7,  6'd20, 6'd21, 6'd29, 6'd12, 6'd28, 6'd17,
        6'd1,  6'd15, 6'd23, 6'd26, 6'd5,  6'd18, 6'd31, 6'd10,
        6'd2,  6'd8,  6'd24, 6'd14, 6'd32, 6'd27, 6'd3,  6'd9,
        6'd19, 6'd13, 6'd30, 6'd6,  6'd22, 6'd11, 6'd4,  6'd25
    };

    // The eight standard S-boxes, each laid out as row * 16 + column.
    localparam nibble_t SBOX_TABLE [0:NumBoxes-1][0:63] = '{
        '{4'd14, 4'd4,  4'd13, 4'd1,  4'd2,  4'd15, 4'd11, 4'd8,
          4'd3,  4'd10, 4'd6,  4'd12, 4'd5,  4'd9,  4'd0,  4'd7,
          4'd0,  4'd15, 4'd7,  4'd4,  4'd14, 4'd2,  4'd13, 4'd1,
          4'd10, 4'd6,  4'd12, 4'd11, 4'd9,  4'd5,  4'd3,  4'd8,
          4'd4,  4'd1,  4'd14, 4'd8,  4'd13, 4'd6,  4'd2,  4'd11,
          4'd15, 4'd12, 4'd9,  4'd7,  4'd3,  4'd10, 4'd5,  4'd0,
          4'd15, 4'd12, 4'd8,  4'd2,  4'd4,  4'd9,  4'd1,  4'd7,
          4'd5,  4'd11, 4'd3,  4'd14, 4'd10, 4'd0,  4'd6,  4'd13},
        '{4'd15, 4'd1,  4'd8,  4'd14, 4'd6,  4'd11, 4'd3,  4'd4,
          4'd9,  4'd7,  4'd2,  4'd13, 4'd12, 4'd0,  4'd5,  4'd10,
          4'd3,  4'd13, 4'd4,  4'd7,  4'd15, 4'd2,  4'd8,  4'd14,
          4'd12, 4'd0,  4'd1,  4'd10, 4'd6,  4'd9,  4'd11, 4'd5,
          4'd0,  4'd14, 4'd7,  4'd11, 4'd10, 4'd4,  4'd13, 4'd1,
          4'd5,  4'd8,  4'd12, 4'd6,  4'd9,  4'd3,  4'd2,  4'd15,
          4'd13, 4'd8,  4'd10, 4'd1,  4'd3,  4'd15, 4'd4,  4'd2,
          4'd11, 4'd6,  4'd7,  4'd12, 4'd0,  4'd5,  4'd14, 4'd9},
        '{4'd10, 4'd0,  4'd9,  4'd14, 4'd6,  4'd3,  4'd15, 4'd5,
          4'd1,  4'd13, 4'd12, 4'd7,  4'd11, 4'd4,  4'd2,  4'd8,
          4'd13, 4'd7,  4'd0,  4'd9,  4'd3,  4'd4,  4'd6,  4'd10,
          4'd2,  4'd8,  4'd5,  4'd14, 4'd12, 4'd11, 4'd15, 4'd1,
          4'd13, 4'd6,  4'd4,  4'd9,  4'd8,  4'd15, 4'd3,  4'd0,
          4'd11, 4'd1,  4'd2,  4'd12, 4'd5,  4'd10, 4'd14, 4'd7,
          4'd1,  4'd10, 4'd13, 4'd0,  4'd6,  4'd9,  4'd8,  4'd7,
          4'd4,  4'd15, 4'd14, 4'd3,  4'd11, 4'd5,  4'd2,  4'd12},
        '{4'd7,  4'd13, 4'd14, 4'd3,  4'd0,  4'd6,  4'd9,  4'd10,
          4'd1,  4'd2,  4'd8,  4'd5,  4'd11, 4'd12, 4'd4,  4'd15,
          4'd13, 4'd8,  4'd11, 4'd5,  4'd6,  4'd15, 4'd0,  4'd3,
          4'd4,  4'd7,  4'd2,  4'd12, 4'd1,  4'd10, 4'd14, 4'd9,
          4'd10, 4'd6,  4'd9,  4'd0,  4'd12, 4'd11, 4'd7,  4'd13,
          4'd15, 4'd1,  4'd3,  4'd14, 4'd5,  4'd2,  4'd8,  4'd4,
          4'd3,  4'd15, 4'd0,  4'd6,  4'd10, 4'd1,  4'd13, 4'd8,
          4'd9,  4'd4,  4'd5,  4'd11, 4'd12, 4'd7,  4'd2,  4'd14},
        '{4'd2,  4'd12, 4'd4,  4'd1,  4'd7,  4'd10, 4'd11, 4'd6,
          4'd8,  4'd5,  4'd3,  4'd15, 4'd13, 4'd0,  4'd14, 4'd9,
          4'd14, 4'd11, 4'd2,  4'd12, 4'd4,  4'd7,  4'd13, 4'd1,
          4'd5,  4'd0,  4'd15, 4'd10, 4'd3,  4'd9,  4'd8,  4'd6,
          4'd4,  4'd2,  4'd1,  4'd11, 4'd10, 4'd13, 4'd7,  4'd8,
          4'd15, 4'd9,  4'd12, 4'd5,  4'd6,  4'd3,  4'd0,  4'd14,
          4'd11, 4'd8,  4'd12, 4'd7,  4'd1,  4'd14, 4'd2,  4'd13,
          4'd6,  4'd15, 4'd0,  4'd9,  4'd10, 4'd4,  4'd5,  4'd3},
        '{4'd12, 4'd1,  4'd10, 4'd15, 4'd9,  4'd2,  4'd6,  4'd8,
          4'd0,  4'd13, 4'd3,  4'd4,  4'd14, 4'd7,  4'd5,  4'd11,
          4'd10, 4'd15, 4'd4,  4'd2,  4'd7,  4'd12, 4'd9,  4'd5,
          4'd6,  4'd1,  4'd13, 4'd14, 4'd0,  4'd11, 4'd3,  4'd8,
          4'd9,  4'd14, 4'd15, 4'd5,  4'd2,  4'd8,  4'd12, 4'd3,
          4'd7,  4'd0,  4'd4,  4'd10, 4'd1,  4'd13, 4'd11, 4'd6,
          4'd4,  4'd3,  4'd2,  4'd12, 4'd9,  4'd5,  4'd15, 4'd10,
          4'd11, 4'd14, 4'd1,  4'd7,  4'd6,  4'd0,  4'd8,  4'd13},
        '{4'd4,  4'd11, 4'd2,  4'd14, 4'd15, 4'd0,  4'd8,  4'd13,
          4'd3,  4'd12, 4'd9,  4'd7,  4'd5,  4'd10, 4'd6,  4'd1,
          4'd13, 4'd0,  4'd11, 4'd7,  4'd4,  4'd9,  4'd1,  4'd10,
          4'd14, 4'd3,  4'd5,  4'd12, 4'd2,  4'd15, 4'd8,  4'd6,
          4'd1,  4'd4,  4'd11, 4'd13, 4'd12, 4'd3,  4'd7,  4'd14,
          4'd10, 4'd15, 4'd6,  4'd8,  4'd0,  4'd5,  4'd9,  4'd2,
          4'd6,  4'd11, 4'd13, 4'd8,  4'd1,  4'd4,  4'd10, 4'd7,
          4'd9,  4'd5,  4'd0,  4'd15, 4'd14, 4'd2,  4'd3,  4'd12},
        '{4'd13, 4'd2,  4'd8,  4'd4,  4'd6,  4'd15, 4'd11, 4'd1,
          4'd10, 4'd9,  4'd3,  4'd14, 4'd5,  4'd0,  4'd12, 4'd7,
          4'd1,  4'd15, 4'd13, 4'd8,  4'd10, 4'd3,  4'd7,  4'd4,
          4'd12, 4'd5,  4'd6,  4'd11, 4'd0,  4'd14, 4'd9,  4'd2,
          4'd7,  4'd11, 4'd4,  4'd1,  4'd9,  4'd12, 4'd14, 4'd2,
          4'd0,  4'd6,  4'd10, 4'd13, 4'd15, 4'd3,  4'd5,  4'd8,
          4'd2,  4'd1,  4'd14, 4'd7,  4'd4,  4'd10, 4'd8,  4'd13,
          4'd15, 4'd12, 4'd9,  4'd0,  4'd3,  4'd5,  4'd6,  4'd11}
    };

    // Expand a 32-bit half to 48 bits with the E table.
    function automatic key_t des_expand(input half_t r);
        key_t x;
        logic [4:0] src;
        for (int i = 0; i < KeyWidth; i++) begin
            src = 5'(6'd32 - E_SEL[i]);
            x[KeyWidth-1-i] = r[src];
        end
        return x;
    endfunction

    // Permute a 32-bit word with the P table.
    function automatic half_t des_permute(input half_t s);
        half_t f;
        logic [4:0] src;
        for (int i = 0; i < HalfWidth; i++) begin
            src = 5'(6'd32 - P_SEL[i]);
            f[HalfWidth-1-i] = s[src];
        end
        return f;
    endfunction

endpackage

// ----- design/des_round_function_top.sv -----
// Channel  | Ports                                  | Direction
// ---------+----------------------------------------+----------
// input    | s_valid, s_ready, s_right_half,        | in
//          | s_round_key                            |
// result   | m_valid, m_ready, m_f_result           | out
//
// Each transfer is latched in an input register, passes through the round
// function logic, and lands in the result register. One item is taken per
// cycle unless m_ready stalls a full pipeline; the throughput is set by the
// two-stage register pipeline. Synchronous active-low reset empties both stages.
// A stalled result holds the result register and, behind it, the input
// register; s_ready drops only when both stages are full.
//
// Depends on des_rf_pkg and des_rf_func.
`timescale 1ns / 1ps

module des_round_function_top (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  des_rf_pkg::half_t s_right_half,
    input  des_rf_pkg::key_t  s_round_key,
    output logic              m_valid,
    input  logic              m_ready,
    output des_rf_pkg::half_t m_f_result
);
    import des_rf_pkg::*;

    logic  in_valid_reg, in_valid_next;
    half_t in_half_reg;
    key_t  in_key_reg;
    logic  out_valid_reg, out_valid_next;
    half_t out_f_reg;
    half_t f_value;
    logic  out_load;
    logic  in_load;

    // Handshake: the result register loads when empty or being drained.
    assign out_load = !out_valid_reg || m_ready;
    assign s_ready  = !in_valid_reg || out_load;
    assign in_load  = s_valid && s_ready;

    always_comb begin
        if (in_load) begin
            in_valid_next = 1'b1;
        end else if (out_load) begin
            in_valid_next = 1'b0;
        end else begin
            in_valid_next = in_valid_reg;
        end
        out_valid_next = out_load ? in_valid_reg : out_valid_reg;
    end

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
        if (in_load) begin
            in_half_reg <= s_right_half;
            in_key_reg  <= s_round_key;
        end
    end

    // Round function logic.
    des_rf_func u_func (
        .right_half (in_half_reg),
        .round_key  (in_key_reg),
        .f_result   (f_value)
    );

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
        if (out_load && in_valid_reg) begin
            out_f_reg <= f_value;
        end
    end

    assign m_valid    = out_valid_reg;
    assign m_f_result = out_f_reg;

    // A full input stage moves into the result register when it has room.
    a_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && out_load |=> m_valid)
        else $error("input stage did not advance into result register");

    // The result register takes the function of the input stage.
    a_result: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && out_load |=> m_f_result == $past(f_value))
        else $error("result register does not match round function");

    // A blocked input stage keeps its item.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !out_load |=> in_valid_reg && $stable(in_half_reg)
            && $stable(in_key_reg))
        else $error("blocked input stage lost its item");

    // An empty input stage always accepts.
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_valid_reg |-> s_ready)
        else $error("empty input stage refused a transfer");

endmodule

// ----- design/des_rf_func.sv -----
// Combinational DES round function: expansion, key mix, S-boxes and P.
// Depends on des_rf_pkg for the tables and helper functions.
`timescale 1ns / 1ps

module des_rf_func (
    input  des_rf_pkg::half_t right_half,
    input  des_rf_pkg::key_t  round_key,
    output des_rf_pkg::half_t f_result
);
    import des_rf_pkg::*;

    key_t  mixed;
    half_t subst;

    // Expand the right half and mix in the round key.
    assign mixed = des_expand(right_half) ^ round_key;

    // Eight S-box lookups; group 0 is the top six bits. The row comes from
    // the outer two bits and the column from the inner four.
    always_comb begin
        logic [BoxInWidth-1:0] six;
        for (int i = 0; i < NumBoxes; i++) begin
            six = mixed[KeyWidth-1-BoxInWidth*i -: BoxInWidth];
            subst[HalfWidth-1-BoxOutWidth*i -: BoxOutWidth] =
                SBOX_TABLE[i][{six[5], six[0], six[4:1]}];
        end
    end

    // Final permutation.
    assign f_result = des_permute(subst);

endmodule

// ----- tb/des_round_function_checker.sv -----
// Checker for the DES round function: watches both channels, predicts f for
// every input transfer and compares each result transfer in order.
// Depends on des_rf_pkg for the port types only; the prediction tables are its own.
`timescale 1ns / 1ps

module des_round_function_checker (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    input  logic              s_ready,
    input  des_rf_pkg::half_t s_right_half,
    input  des_rf_pkg::key_t  s_round_key,
    input  logic              m_valid,
    input  logic              m_ready,
    input  des_rf_pkg::half_t m_f_result,
    output int                mismatch_count,
    output int                results_checked,
    output int                results_pending
);
    import des_rf_pkg::*;

    // Only the first few mismatches are printed; all of them are counted.
    localparam int PrintLimit = 40;

    // Expansion selection, bit 1 is the most significant bit.
    localparam int E_PICK [48] = '{
        32, 1, 2, 3, 4, 5, 4, 5, 6, 7, 8, 9,
        8, 9, 10, 11, 12, 13, 12, 13, 14, 15, 16, 17,
        16, 17, 18, 19, 20, 21, 20, 21, 22, 23, 24, 25,
        24, 25, 26, 27, 28, 29, 28, 29, 30, 31, 32, 1
    };

    // Output permutation, bit 1 is the most significant bit.
    localparam int P_PICK [32] = '{
        16, 7, 20, 21, 29, 12, 28, 17, 1, 15, 23, 26, 5, 18, 31, 10,
        2, 8, 24, 14, 32, 27, 3, 9, 19, 13, 30, 6, 22, 11, 4, 25
    };

    // S-box rows packed as sixteen nibbles, column 0 in the top nibble.
    // Entry 4 * box + row holds one row of one box.
    localparam logic [63:0] SBOX_ROW [32] = '{
        64'hE4D12FB83A6C5907, 64'h0F74E2D1A6CB9538,
        64'h41E8D62BFC973A50, 64'hFC8249175B3EA06D,
        64'hF18E6B34972DC05A, 64'h3D47F28EC01A69B5,
        64'h0E7BA4D158C6932F, 64'hD8A13F42B67C05E9,
        64'hA09E63F51DC7B428, 64'hD709346A285ECBF1,
        64'hD6498F30B12C5AE7, 64'h1AD069874FE3B52C,
        64'h7DE3069A1285BC4F, 64'hD8B56F03472C1AE9,
        64'hA690CB7DF13E5284, 64'h3F06A1D8945BC72E,
        64'h2C417AB6853FD0E9, 64'hEB2C47D150FA3986,
        64'h421BAD78F9C5630E, 64'hB8C71E2D6F09A453,
        64'hC1AF92680D34E75B, 64'hAF427C9561DE0B38,
        64'h9EF528C3704A1DB6, 64'h432C95FABE17608D,
        64'h4B2EF08D3C975A61, 64'hD0B7491AE35C2F86,
        64'h14BDC37EAF680592, 64'h6BD814A7950FE23C,
        64'hD2846FB1A93E50C7, 64'h1FD8A374C56B0E92,
        64'h7B419CE206ADF358, 64'h21E74A8DFC90356B
    };

    half_t f_expected [$];

    // Round function f: expand, mix in the subkey, substitute, permute.
    function automatic half_t feistel_f(input half_t right, input key_t subkey);
        key_t        mixed;
        half_t       joined;
        half_t       permuted;
        logic [5:0]  group;
        logic [63:0] row_bits;
        int          col;
        for (int i = 0; i < 48; i++) begin
            mixed[47 - i] = right[32 - E_PICK[i]];
        end
        mixed = mixed ^ subkey;
        // The outer two bits of each group pick the row, the inner four the column.
        for (int b = 0; b < 8; b++) begin
            group    = mixed[47 - 6 * b -: 6];
            row_bits = SBOX_ROW[4 * b + 2 * group[5] + group[0]];
            col      = group[4:1];
            joined[31 - 4 * b -: 4] = row_bits[63 - 4 * col -: 4];
        end
        for (int i = 0; i < 32; i++) begin
            permuted[31 - i] = joined[32 - P_PICK[i]];
        end
        return permuted;
    endfunction

    task automatic report_mismatch(input string what, input half_t got, input half_t want);
        if (mismatch_count < PrintLimit) begin
            $display("[%0t] %s: got %h, expected %h", $realtime, what, got, want);
        end
        mismatch_count++;
    endtask

    initial begin
        mismatch_count  = 0;
        results_checked = 0;
        results_pending = 0;
        // Guard the predictor itself with the textbook first-round value.
        if (feistel_f(32'hF0AAF0AA, 48'h1B02EFFC7072) != 32'h234AA9BB) begin
            report_mismatch("predictor known-answer value", feistel_f(32'hF0AAF0AA,
                            48'h1B02EFFC7072), 32'h234AA9BB);
        end
    end

    // Record an expectation for each input transfer, then check each result transfer.
    always @(posedge aclk) begin
        half_t want;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                f_expected.push_back(feistel_f(s_right_half, s_round_key));
            end
            if (m_valid && m_ready) begin
                if (f_expected.size() == 0) begin
                    report_mismatch("result transfer with nothing pending", m_f_result, '0);
                end else begin
                    want = f_expected.pop_front();
                    if (m_f_result !== want) begin
                        report_mismatch("f_result", m_f_result, want);
                    end
                    results_checked++;
                end
            end
            results_pending = f_expected.size();
        end
    end

endmodule

// ----- tb/testbench.sv -----
// Top of the DES round function testbench: clock, reset, stimulus, receiver
// stalls, watchdog and verdict. Depends on des_rf_pkg, des_round_function_top
// and des_round_function_checker.
`timescale 1ns / 1ps

module testbench;
    import des_rf_pkg::*;

    localparam int HoldCycles  = 64;
    localparam int StallLimit  = 1000;
    localparam int DrainCycles = 10;

    logic  aclk         = 1'b0;
    logic  aresetn      = 1'b0;
    logic  s_valid      = 1'b0;
    logic  s_ready;
    half_t s_right_half = '0;
    key_t  s_round_key  = '0;
    logic  m_valid;
    logic  m_ready      = 1'b0;
    half_t m_f_result;

    int mismatch_count;
    int results_checked;
    int results_pending;

    bit src_idle  = 1'b0;
    bit sink_idle = 1'b0;
    int hold_asked = 0;
    int hold_done  = 0;
    int items_sent = 0;
    int stall_cycles = 0;

    always #2 aclk = ~aclk;

    des_round_function_top dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_right_half (s_right_half),
        .s_round_key  (s_round_key),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_f_result   (m_f_result)
    );

    des_round_function_checker scoreboard (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_right_half    (s_right_half),
        .s_round_key     (s_round_key),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_f_result      (m_f_result),
        .mismatch_count  (mismatch_count),
        .results_checked (results_checked),
        .results_pending (results_pending)
    );

    // Offer one item, with an occasional gap first, and hold it until the transfer.
    // Called and returns at a falling edge.
    task automatic send_item(input half_t right, input key_t subkey);
        if (src_idle && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge aclk);
        end
        s_valid      <= 1'b1;
        s_right_half <= right;
        s_round_key  <= subkey;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
        @(negedge aclk);
    endtask

    // Random items: mostly dense random data, some sparse or saturated fields.
    task automatic send_random(input int count);
        logic [63:0] wide;
        half_t       right;
        key_t        subkey;
        repeat (count) begin
            wide   = {$urandom(), $urandom()};
            right  = $urandom();
            subkey = wide[47:0];
            case ($urandom_range(0, 9))
                0: begin
                    right  = half_t'(1) << $urandom_range(0, 31);
                    subkey = key_t'(1) << $urandom_range(0, 47);
                end
                1: subkey = $urandom_range(0, 1) ? '1 : '0;
                2: begin
                    case ($urandom_range(0, 3))
                        0: right = '0;
                        1: right = '1;
                        2: right = 32'hAAAAAAAA;
                        default: right = 32'h55555555;
                    endcase
                end
                default: ;
            endcase
            send_item(right, subkey);
        end
    endtask

    // Receiver: ready most of the time, with random stall bursts and the
    // occasional long hold-off that the stimulus asks for.
    initial begin
        forever begin
            @(negedge aclk);
            if (hold_asked != hold_done) begin
                hold_done++;
                m_ready <= 1'b0;
                repeat (HoldCycles) @(negedge aclk);
                m_ready <= 1'b1;
            end else if (sink_idle && $urandom_range(0, 4) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(negedge aclk);
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Watchdog on cycles without any transfer on either channel.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= StallLimit) begin
            $display("Watchdog: no transfer for %0d cycles, %0d results still pending",
                     stall_cycles, results_pending);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed corners: field extremes, the published first-round value,
        // the wrap-around bits of the expansion, and every S-box row selection.
        send_item('0, '0);
        send_item('1, '1);
        send_item('0, '1);
        send_item('1, '0);
        send_item(32'hF0AAF0AA, 48'h1B02EFFC7072);
        send_item(32'h80000000, '0);
        send_item(32'h00000001, '0);
        send_item(32'hAAAAAAAA, 48'h555555555555);
        send_item(32'h55555555, 48'hAAAAAAAAAAAA);
        send_item('0, {8{6'b000000}});
        send_item('0, {8{6'b000001}});
        send_item('0, {8{6'b100000}});
        send_item('0, {8{6'b100001}});
        send_item('0, {8{6'b011110}});
        send_item('0, 48'h800000000000);
        send_item('0, 48'h000000000001);
        send_item(32'h12345678, 48'h0F1E2D3C4B5A);

        // Both sides idle at random; starts with a long receiver hold-off.
        src_idle  = 1'b1;
        sink_idle = 1'b1;
        hold_asked++;
        send_random(500);

        // Only the sender idles.
        sink_idle = 1'b0;
        send_random(400);

        // Only the receiver idles, with a second long hold-off.
        src_idle  = 1'b0;
        sink_idle = 1'b1;
        hold_asked++;
        send_random(400);

        // Back-to-back stretch at full rate to finish.
        sink_idle = 1'b0;
        send_random(450);
        s_valid <= 1'b0;

        while (results_pending != 0) @(posedge aclk);
        repeat (DrainCycles) @(posedge aclk);

        $display("Run covered %0d input transfers and %0d checked results,", items_sent,
                 results_checked);
        $display("with directed corners, random data, stall bursts and two long output holds.");
        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
